/* rtl/core/qrag_pkg.sv */
// qrag_pkg: shared widths and word types for the gravity-compensated quaternion rotation
// used by qrag_clip and quat_rotate_accel_remove_gravity_top; no dependencies
`timescale 1ns / 1ps

package qrag_pkg;

    // sample and quaternion formats
    localparam int SAMPLE_WIDTH   = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;

    // gravity offset after reset, one g in the sample format
    localparam int GRAVITY_RESET = 4096;

    // datapath widths
    localparam int PROD1_WIDTH = SAMPLE_WIDTH + QUAT_WIDTH;  // q * a
    localparam int T_WIDTH     = PROD1_WIDTH + 2;            // sum of three products
    localparam int PROD2_WIDTH = T_WIDTH + QUAT_WIDTH;       // t * q
    localparam int R_WIDTH     = PROD2_WIDTH + 2;            // sum of four products
    localparam int DROP_BITS   = 2 * QUAT_FRAC_BITS;
    localparam int RND_WIDTH   = R_WIDTH + 1 - DROP_BITS;    // after rounding shift

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
        logic signed [QUAT_WIDTH-1:0]   quat_w;
        logic signed [QUAT_WIDTH-1:0]   quat_x;
        logic signed [QUAT_WIDTH-1:0]   quat_y;
        logic signed [QUAT_WIDTH-1:0]   quat_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] global_x;
        logic signed [SAMPLE_WIDTH-1:0] global_y;
        logic signed [SAMPLE_WIDTH-1:0] global_z;
        logic                           saturated;
    } result_t;

endpackage

/* rtl/core/qrag_clip.sv */
// qrag_clip: saturates a wide signed value to the sample width and flags clipping
// depends on qrag_pkg for the sample width
`timescale 1ns / 1ps

module qrag_clip #(
    parameter int IN_WIDTH = 25
) (
    input  logic signed [IN_WIDTH-1:0]               value,
    output logic signed [qrag_pkg::SAMPLE_WIDTH-1:0] clipped,
    output logic                                     clip_flag
);

    localparam int SW = qrag_pkg::SAMPLE_WIDTH;

    logic in_range;

    // in range when every bit above the output sign bit matches the sign
    assign in_range = (value[IN_WIDTH-1:SW-1] == {(IN_WIDTH-SW+1){1'b0}})
                   || (value[IN_WIDTH-1:SW-1] == {(IN_WIDTH-SW+1){1'b1}});

    always_comb
    begin
        clip_flag = !in_range;
        if (in_range)
        begin
            clipped = value[SW-1:0];
        end
        else if (value[IN_WIDTH-1])
        begin
            clipped = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            clipped = {1'b0, {(SW-1){1'b1}}};
        end
    end

endmodule

/* rtl/core/quat_rotate_accel_remove_gravity_top.sv */
// quat_rotate_accel_remove_gravity_top: rotates a sensor-frame sample by q * p * conj(q)
// and removes the gravity offset from y; depends on qrag_pkg and qrag_clip
`timescale 1ns / 1ps
// throughput: one word per cycle while the result side does not stall, set by the five
// register stages (two multiplier stages of 12 products each, two adder stages, one
// saturate stage)
// stages advance independently, so bubbles close up while the result side stalls
// reset: all stage valid bits clear, gravity offset returns to 4096 (one g)

module quat_rotate_accel_remove_gravity_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // sample word channel
    input  logic                                     sample_valid,
    output logic                                     sample_stall,
    input  qrag_pkg::sample_t                        sample,
    // result word channel
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output qrag_pkg::result_t                        result,
    // gravity offset write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic signed [qrag_pkg::SAMPLE_WIDTH-1:0] cfg_data
);

    localparam int SW  = qrag_pkg::SAMPLE_WIDTH;
    localparam int QW  = qrag_pkg::QUAT_WIDTH;
    localparam int P1W = qrag_pkg::PROD1_WIDTH;
    localparam int TW  = qrag_pkg::T_WIDTH;
    localparam int P2W = qrag_pkg::PROD2_WIDTH;
    localparam int RW  = qrag_pkg::R_WIDTH;
    localparam int DB  = qrag_pkg::DROP_BITS;
    localparam int NW  = qrag_pkg::RND_WIDTH;

    // ------------------------------------------------------------------
    // gravity offset register, always writable
    // ------------------------------------------------------------------
    logic signed [SW-1:0] gravity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= SW'(qrag_pkg::GRAVITY_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            gravity_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // stage control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !result_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign sample_stall = !en1;
    assign result_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= sample_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: the twelve products of q * p
    // ------------------------------------------------------------------
    logic signed [P1W-1:0] xa_x_next, ya_y_next, za_z_next;
    logic signed [P1W-1:0] wa_x_next, ya_z_next, za_y_next;
    logic signed [P1W-1:0] wa_y_next, xa_z_next, za_x_next;
    logic signed [P1W-1:0] wa_z_next, xa_y_next, ya_x_next;

    assign xa_x_next = sample.quat_x * sample.accel_x;
    assign ya_y_next = sample.quat_y * sample.accel_y;
    assign za_z_next = sample.quat_z * sample.accel_z;
    assign wa_x_next = sample.quat_w * sample.accel_x;
    assign ya_z_next = sample.quat_y * sample.accel_z;
    assign za_y_next = sample.quat_z * sample.accel_y;
    assign wa_y_next = sample.quat_w * sample.accel_y;
    assign xa_z_next = sample.quat_x * sample.accel_z;
    assign za_x_next = sample.quat_z * sample.accel_x;
    assign wa_z_next = sample.quat_w * sample.accel_z;
    assign xa_y_next = sample.quat_x * sample.accel_y;
    assign ya_x_next = sample.quat_y * sample.accel_x;

    logic signed [P1W-1:0] xa_x_reg, ya_y_reg, za_z_reg;
    logic signed [P1W-1:0] wa_x_reg, ya_z_reg, za_y_reg;
    logic signed [P1W-1:0] wa_y_reg, xa_z_reg, za_x_reg;
    logic signed [P1W-1:0] wa_z_reg, xa_y_reg, ya_x_reg;
    logic signed [QW-1:0]  qw1_reg, qx1_reg, qy1_reg, qz1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            xa_x_reg <= xa_x_next;
            ya_y_reg <= ya_y_next;
            za_z_reg <= za_z_next;
            wa_x_reg <= wa_x_next;
            ya_z_reg <= ya_z_next;
            za_y_reg <= za_y_next;
            wa_y_reg <= wa_y_next;
            xa_z_reg <= xa_z_next;
            za_x_reg <= za_x_next;
            wa_z_reg <= wa_z_next;
            xa_y_reg <= xa_y_next;
            ya_x_reg <= ya_x_next;
            qw1_reg  <= sample.quat_w;
            qx1_reg  <= sample.quat_x;
            qy1_reg  <= sample.quat_y;
            qz1_reg  <= sample.quat_z;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: t = q * p, scalar part kept negated (nw = -tw)
    // ------------------------------------------------------------------
    logic signed [TW-1:0] nw_next, tx_next, ty_next, tz_next;

    assign nw_next = TW'(xa_x_reg) + TW'(ya_y_reg) + TW'(za_z_reg);
    assign tx_next = TW'(wa_x_reg) + TW'(ya_z_reg) - TW'(za_y_reg);
    assign ty_next = TW'(wa_y_reg) - TW'(xa_z_reg) + TW'(za_x_reg);
    assign tz_next = TW'(wa_z_reg) + TW'(xa_y_reg) - TW'(ya_x_reg);

    logic signed [TW-1:0] nw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [QW-1:0] qw2_reg, qx2_reg, qy2_reg, qz2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            nw_reg  <= nw_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            tz_reg  <= tz_next;
            qw2_reg <= qw1_reg;
            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
            qz2_reg <= qz1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: the twelve products of t * conj(q)
    // ------------------------------------------------------------------
    logic signed [P2W-1:0] rx0_next, rx1_next, rx2_next, rx3_next;
    logic signed [P2W-1:0] ry0_next, ry1_next, ry2_next, ry3_next;
    logic signed [P2W-1:0] rz0_next, rz1_next, rz2_next, rz3_next;

    assign rx0_next = nw_reg * qx2_reg;
    assign rx1_next = tx_reg * qw2_reg;
    assign rx2_next = ty_reg * qz2_reg;
    assign rx3_next = tz_reg * qy2_reg;
    assign ry0_next = nw_reg * qy2_reg;
    assign ry1_next = tx_reg * qz2_reg;
    assign ry2_next = ty_reg * qw2_reg;
    assign ry3_next = tz_reg * qx2_reg;
    assign rz0_next = nw_reg * qz2_reg;
    assign rz1_next = tx_reg * qy2_reg;
    assign rz2_next = ty_reg * qx2_reg;
    assign rz3_next = tz_reg * qw2_reg;

    logic signed [P2W-1:0] rx0_reg, rx1_reg, rx2_reg, rx3_reg;
    logic signed [P2W-1:0] ry0_reg, ry1_reg, ry2_reg, ry3_reg;
    logic signed [P2W-1:0] rz0_reg, rz1_reg, rz2_reg, rz3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            rx0_reg <= rx0_next;
            rx1_reg <= rx1_next;
            rx2_reg <= rx2_next;
            rx3_reg <= rx3_next;
            ry0_reg <= ry0_next;
            ry1_reg <= ry1_next;
            ry2_reg <= ry2_next;
            ry3_reg <= ry3_next;
            rz0_reg <= rz0_next;
            rz1_reg <= rz1_next;
            rz2_reg <= rz2_next;
            rz3_reg <= rz3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum, round half up and drop the quaternion fraction bits
    // ------------------------------------------------------------------
    localparam logic signed [RW:0] HALF_LSB = {{(RW+1-DB){1'b0}}, 1'b1, {(DB-1){1'b0}}};

    logic signed [RW-1:0] rx_sum, ry_sum, rz_sum;
    logic signed [RW:0]   rx_half, ry_half, rz_half;
    logic signed [NW-1:0] gx_next, gy_next, gz_next;

    assign rx_sum = RW'(rx0_reg) + RW'(rx1_reg) - RW'(rx2_reg) + RW'(rx3_reg);
    assign ry_sum = RW'(ry0_reg) + RW'(ry1_reg) + RW'(ry2_reg) - RW'(ry3_reg);
    assign rz_sum = RW'(rz0_reg) - RW'(rz1_reg) + RW'(rz2_reg) + RW'(rz3_reg);

    assign rx_half = (RW+1)'(rx_sum) + HALF_LSB;
    assign ry_half = (RW+1)'(ry_sum) + HALF_LSB;
    assign rz_half = (RW+1)'(rz_sum) + HALF_LSB;

    // arithmetic drop of the low bits is a floor
    assign gx_next = rx_half[RW:DB];
    assign gy_next = ry_half[RW:DB];
    assign gz_next = rz_half[RW:DB];

    logic signed [NW-1:0] gx_reg, gy_reg, gz_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            gz_reg <= gz_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: remove gravity from y, saturate all three components
    // ------------------------------------------------------------------
    logic signed [NW:0]   gy_comp;
    logic signed [SW-1:0] out_x, out_y, out_z;
    logic                 sat_x, sat_y, sat_z;

    assign gy_comp = (NW+1)'(gy_reg) - (NW+1)'(gravity_reg);

    qrag_clip #(
        .IN_WIDTH (NW)
    ) u_clip_x (
        .value     (gx_reg),
        .clipped   (out_x),
        .clip_flag (sat_x)
    );

    qrag_clip #(
        .IN_WIDTH (NW + 1)
    ) u_clip_y (
        .value     (gy_comp),
        .clipped   (out_y),
        .clip_flag (sat_y)
    );

    qrag_clip #(
        .IN_WIDTH (NW)
    ) u_clip_z (
        .value     (gz_reg),
        .clipped   (out_z),
        .clip_flag (sat_z)
    );

    qrag_pkg::result_t result_next;
    qrag_pkg::result_t result_reg;

    always_comb
    begin
        result_next.global_x  = out_x;
        result_next.global_y  = out_y;
        result_next.global_z  = out_z;
        result_next.saturated = sat_x | sat_y | sat_z;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* tb/sv/tb_quat_rotate_accel_remove_gravity_top.sv */
// tb_quat_rotate_accel_remove_gravity_top: self-checking bench for the gravity-compensated
// quaternion rotation, with its own exact integer predictor and an in-order result scoreboard
// depends on qrag_pkg and quat_rotate_accel_remove_gravity_top
`timescale 1ns / 1ps

module tb_quat_rotate_accel_remove_gravity_top;

    import qrag_pkg::*;

    // bench timing: 4 ns clock, generous overall limit
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 150;
    localparam int DROP          = 2 * QUAT_FRAC_BITS;

    // scoreboard: predicts each accepted sample word and checks result words in order
    class gravity_rotation_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] gravity_offset;
        result_t pending_rotations[$];
        int failures;
        int words_seen;
        int results_checked;
        int clipped_results;

        function new();
            gravity_offset  = GRAVITY_RESET[SAMPLE_WIDTH-1:0];
            failures        = 0;
            words_seen      = 0;
            results_checked = 0;
            clipped_results = 0;
        endfunction

        function void set_gravity(logic signed [SAMPLE_WIDTH-1:0] g);
            gravity_offset = g;
        endfunction

        function int pending();
            return pending_rotations.size();
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] clamp_sample(longint v, inout bit clipped);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                clipped = 1'b1;
                return hi[SAMPLE_WIDTH-1:0];
            end
            if (v < lo)
            begin
                clipped = 1'b1;
                return lo[SAMPLE_WIDTH-1:0];
            end
            return v[SAMPLE_WIDTH-1:0];
        endfunction

        // exact q * p * conj(q), round half up, subtract gravity from y, saturate
        function result_t rotate_and_compensate(sample_t s);
            longint ax, ay, az, qw, qx, qy, qz;
            longint tw, tx, ty, tz, rx, ry, rz, half;
            bit clipped;
            result_t r;
            ax = longint'($signed(s.accel_x));
            ay = longint'($signed(s.accel_y));
            az = longint'($signed(s.accel_z));
            qw = longint'($signed(s.quat_w));
            qx = longint'($signed(s.quat_x));
            qy = longint'($signed(s.quat_y));
            qz = longint'($signed(s.quat_z));
            tw = -(qx * ax + qy * ay + qz * az);
            tx = qw * ax + qy * az - qz * ay;
            ty = qw * ay - qx * az + qz * ax;
            tz = qw * az + qx * ay - qy * ax;
            rx = -tw * qx + tx * qw - ty * qz + tz * qy;
            ry = -tw * qy + tx * qz + ty * qw - tz * qx;
            rz = -tw * qz - tx * qy + ty * qx + tz * qw;
            half = longint'(1) <<< (DROP - 1);
            clipped = 1'b0;
            r.global_x  = clamp_sample((rx + half) >>> DROP, clipped);
            r.global_y  = clamp_sample(((ry + half) >>> DROP) - longint'(gravity_offset),
                                       clipped);
            r.global_z  = clamp_sample((rz + half) >>> DROP, clipped);
            r.saturated = clipped;
            return r;
        endfunction

        function void note_sample(sample_t s);
            pending_rotations.insert(pending_rotations.size(), rotate_and_compensate(s));
            words_seen++;
        endfunction

        function void report_field(string field, longint want, longint got);
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_rotations.size() == 0)
            begin
                failures++;
                $display(
                    "%0t ns: result word with nothing pending, expected none, got %0d %0d %0d %0b",
                    $time, $signed(got.global_x), $signed(got.global_y),
                    $signed(got.global_z), got.saturated);
                return;
            end
            want = pending_rotations.pop_front();
            results_checked++;
            if (want.saturated)
                clipped_results++;
            if (got.global_x !== want.global_x)
                report_field("global_x", $signed(want.global_x), $signed(got.global_x));
            if (got.global_y !== want.global_y)
                report_field("global_y", $signed(want.global_y), $signed(got.global_y));
            if (got.global_z !== want.global_z)
                report_field("global_z", $signed(want.global_z), $signed(got.global_z));
            if (got.saturated !== want.saturated)
                report_field("saturated", want.saturated, got.saturated);
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    // sample word channel
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    // result word channel
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    // gravity offset writes
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic signed [SAMPLE_WIDTH-1:0] cfg_data;

    gravity_rotation_scoreboard rotations = new();
    int offsets_used = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_left = 0;
    int stall_cycle = 0;

    always #2 clk = ~clk;

    quat_rotate_accel_remove_gravity_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // monitor: every handshake is judged at the rising edge
    // result check goes first, a word accepted now cannot come back in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                rotations.check_result(result);
            if (sample_valid && !sample_stall)
                rotations.note_sample(sample);
        end
    end

    // result side stalls on a pattern that switches mode at random intervals:
    // free running, light random, heavy random, and a long periodic hold
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 200);
            end
            stall_left--;
            stall_cycle++;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ((stall_cycle % 16) < 11);
            endcase
        end
    end

    // hard stop for a hung pipeline
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_quat_rotate_accel_remove_gravity_top NOT OK");
        $finish;
    end

    // one of the corner values of a 16-bit field, or any pattern at all
    function automatic int extreme_value();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return 16384;
            6:       return -16384;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic sample_t make_sample(int ax, int ay, int az,
                                            int qw, int qx, int qy, int qz);
        sample_t s;
        s.accel_x = ax[SAMPLE_WIDTH-1:0];
        s.accel_y = ay[SAMPLE_WIDTH-1:0];
        s.accel_z = az[SAMPLE_WIDTH-1:0];
        s.quat_w  = qw[QUAT_WIDTH-1:0];
        s.quat_x  = qx[QUAT_WIDTH-1:0];
        s.quat_y  = qy[QUAT_WIDTH-1:0];
        s.quat_z  = qz[QUAT_WIDTH-1:0];
        return s;
    endfunction

    // mostly realistic words: a unit quaternion in any orientation and accel within +-4 g;
    // the rest are raw bit patterns and corner values that drive saturation
    function automatic sample_t random_sample();
        int v[7];
        int pick;
        int i;
        real qw, qx, qy, qz, norm, k;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            for (i = 0; i < 3; i++)
                v[i] = int'($urandom_range(0, 32768)) - 16384;
            qw = real'(int'($urandom_range(0, 32768)) - 16384);
            qx = real'(int'($urandom_range(0, 32768)) - 16384);
            qy = real'(int'($urandom_range(0, 32768)) - 16384);
            qz = real'(int'($urandom_range(0, 32768)) - 16384);
            norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
            if (norm < 1.0)
            begin
                v[3] = 16384;
                v[4] = 0;
                v[5] = 0;
                v[6] = 0;
            end
            else
            begin
                k = 16384.0 / norm;
                v[3] = $rtoi(qw * k);
                v[4] = $rtoi(qx * k);
                v[5] = $rtoi(qy * k);
                v[6] = $rtoi(qz * k);
            end
        end
        else if (pick < 8)
        begin
            for (i = 0; i < 7; i++)
                v[i] = int'($urandom());
        end
        else
        begin
            for (i = 0; i < 7; i++)
                v[i] = extreme_value();
        end
        return make_sample(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    endfunction

    // present one word from a falling edge and hold it until accepted;
    // valid stays high on return so back-to-back words leave no bubble
    task automatic push_sample(input sample_t s);
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // bursts of random length with random gaps, some gaps of zero
    task automatic run_random(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                push_sample(random_sample());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
        end
        sample_valid <= 1'b0;
    endtask

    // gravity offset changes only on an empty pipeline
    task automatic write_gravity(input logic signed [SAMPLE_WIDTH-1:0] g);
        cfg_data  <= g;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rotations.set_gravity(g);
        offsets_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (rotations.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int offsets[RANDOM_PHASES];
        int phase_idx;
        int raw;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words under the reset gravity offset of one g
        offsets_used = 1;
        // identity rotation, zero and full-scale accel, y pushed past the negative rail
        push_sample(make_sample(0, 0, 0, 16384, 0, 0, 0));
        push_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
        push_sample(make_sample(32767, 32767, 32767, 16384, 0, 0, 0));
        push_sample(make_sample(-32768, -32768, -32768, 16384, 0, 0, 0));
        push_sample(make_sample(4096, -4096, 1, 16384, 0, 0, 0));
        // quarter turns about each axis, half turn about x, negated identity
        push_sample(make_sample(0, 4096, 0, 11585, 11585, 0, 0));
        push_sample(make_sample(4096, 0, 0, 11585, 0, 11585, 0));
        push_sample(make_sample(4096, 0, 0, 11585, 0, 0, 11585));
        push_sample(make_sample(1000, 2000, 3000, 0, 16384, 0, 0));
        push_sample(make_sample(12345, -2345, 345, -16384, 0, 0, 0));
        // quaternions far from unit length scale the vector by |q|^2; the first of these clips
        push_sample(make_sample(8192, 8192, 8192, -16384, -16384, -16384, -16384));
        push_sample(make_sample(-1, -1, -1, 16384, 16384, 16384, 16384));
        push_sample(make_sample(1, 2, 3, -32768, 0, 0, 0));
        // patterns outside the quaternion range, read as two's complement
        push_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        push_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        // rounding ties at |q|^2 of one quarter: +0.5 and +1.5 round up, -0.5 and -1.5 too
        push_sample(make_sample(2, -2, 1, 8192, 0, 0, 0));
        push_sample(make_sample(6, -6, -6, 8192, 0, 0, 0));
        // tiny quaternion, then an arbitrary mixed word
        push_sample(make_sample(32767, -32768, 32767, 1, 0, 0, 0));
        push_sample(make_sample(-20000, 15000, 30000, 3000, -7000, 12000, -9000));
        sample_valid <= 1'b0;

        // random phases, each under its own gravity offset, rails included
        raw = int'($urandom());
        offsets = '{0, 32767, -32768, raw, -4096, 4096};
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            drain_results();
            write_gravity(offsets[phase_idx][SAMPLE_WIDTH-1:0]);
            run_random(PHASE_WORDS);
        end
        drain_results();

        $display("checked %0d of %0d sample words across %0d gravity offsets",
                 rotations.results_checked, rotations.words_seen, offsets_used);
        $display("%0d results expected to clip, %0d failures",
                 rotations.clipped_results, rotations.failures);
        if (rotations.failures == 0 && rotations.pending() == 0)
            $display("tb_quat_rotate_accel_remove_gravity_top OK");
        else
            $display("tb_quat_rotate_accel_remove_gravity_top NOT OK");
        $finish;
    end

endmodule

/* quat_rotate_accel_remove_gravity_top.f */
rtl/core/qrag_pkg.sv
rtl/core/qrag_clip.sv
rtl/core/quat_rotate_accel_remove_gravity_top.sv
tb/sv/tb_quat_rotate_accel_remove_gravity_top.sv
